// ===== hdl/nec_ir_frame_decoder_defines.svh =====
// Assertion macros used by the NEC IR decoder checker.
`ifndef NEC_IR_FRAME_DECODER_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet in reset
`define NEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet in reset
`define NEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/nec_pkg.sv =====
// Types and constants of the NEC IR frame decoder.
`default_nettype none
package nec_pkg;

    // Frame geometry
    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned NUM_THR    = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam logic [7:0]  BYTE_ONES  = 8'hFF;

    // Threshold reset values, in register order
    localparam logic [PERIOD_W-1:0] THR_RESET [NUM_THR] = '{
        16'd250, 16'd1200, 16'd2000, 16'd3000, 16'd6000, 16'd12000
    };

    // Opcodes
    localparam logic OP_CAPTURE = 1'b0;

    // Period bands
    localparam logic [2:0] BAND_ERROR  = 3'd0;
    localparam logic [2:0] BAND_SHORT  = 3'd1;
    localparam logic [2:0] BAND_LONG   = 3'd2;
    localparam logic [2:0] BAND_REPEAT = 3'd3;
    localparam logic [2:0] BAND_HEADER = 3'd4;
    localparam logic [2:0] BAND_LEAD   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_TAKEN    = 2'd0;
    localparam logic [1:0] ST_VALID    = 2'd1;
    localparam logic [1:0] ST_NOTREADY = 2'd2;
    localparam logic [1:0] ST_BADCHECK = 2'd3;

    typedef struct packed {
        logic                opcode;
        logic [PERIOD_W-1:0] period;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       command;
        logic [CNT_W-1:0] bit_count;
    } t_out_word;

endpackage
`default_nettype wire

// ===== hdl/nec_ir_frame_decoder.sv =====
// NEC IR frame decoder: period sorting, bit shifter and frame check.
`default_nettype none
// One result word per input word. A word can be accepted every cycle
// unless the receiver stalls the result register; each word is held in
// the input register and its result in the result register. The per-word
// work is a single pass of six threshold compares, a 32-bit shift and two
// byte checks against the held frame, with the frame state updated in the
// same cycle. The user must write the threshold registers through the
// configuration port only while the block is idle; the block itself does
// not enforce this. Indexes 6 and 7 are ignored. A read word returns
// status 1 and the command when 32 bits are held and both bytes check,
// status 3 on a failed check, status 2 when the frame is incomplete.
module nec_ir_frame_decoder (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  nec_pkg::t_in_word                    i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output nec_pkg::t_out_word                   o_out_data,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [nec_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [nec_pkg::PERIOD_W-1:0]         i_cfg_data
);
    import nec_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BITS);

    logic                r_in_valid;
    t_in_word            r_in_data;
    logic                r_out_valid;
    t_out_word           r_out_data;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]    r_bits, n_bits;
    logic [PERIOD_W-1:0] r_thr [NUM_THR];
    logic                out_free;
    logic                adv;
    logic [2:0]          band;
    t_out_word           n_out;

    // Period band, first matching threshold wins
    function automatic logic [2:0] sort_period(
        input logic [PERIOD_W-1:0] p,
        input logic [PERIOD_W-1:0] t0, t1, t2, t3, t4, t5
    );
        logic [2:0] b;
        if (p < t0)      b = BAND_ERROR;
        else if (p < t1) b = BAND_SHORT;
        else if (p < t2) b = BAND_LONG;
        else if (p < t3) b = BAND_REPEAT;
        else if (p < t4) b = BAND_HEADER;
        else if (p < t5) b = BAND_LEAD;
        else             b = BAND_ERROR;
        return b;
    endfunction

    // Handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign adv         = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign band = sort_period(r_in_data.period, r_thr[0], r_thr[1], r_thr[2],
                              r_thr[3], r_thr[4], r_thr[5]);

    // Decode pass
    always_comb begin
        n_shift         = r_shift;
        n_bits          = r_bits;
        n_out.status    = ST_TAKEN;
        n_out.command   = '0;
        if (r_in_data.opcode == OP_CAPTURE) begin
            if (r_bits != FULL_CNT) begin
                unique case (band)
                    BAND_SHORT: begin
                        n_shift = {1'b0, r_shift[FRAME_BITS-1:1]};
                        n_bits  = r_bits + CNT_W'(1);
                    end
                    BAND_LONG: begin
                        n_shift = {1'b1, r_shift[FRAME_BITS-1:1]};
                        n_bits  = r_bits + CNT_W'(1);
                    end
                    BAND_HEADER: begin
                        n_shift = '0;
                        n_bits  = '0;
                    end
                    BAND_REPEAT: begin
                        if (r_bits == '0) n_bits = FULL_CNT;
                    end
                    default: ;
                endcase
            end
        end else begin
            if (r_bits != FULL_CNT) begin
                n_out.status = ST_NOTREADY;
            end else begin
                n_bits = '0;
                if (((r_shift[7:0] ^ r_shift[15:8]) == BYTE_ONES) &&
                    ((r_shift[23:16] ^ r_shift[31:24]) == BYTE_ONES)) begin
                    n_out.status  = ST_VALID;
                    n_out.command = r_shift[23:16];
                end else begin
                    n_out.status = ST_BADCHECK;
                end
            end
        end
        n_out.bit_count = n_bits;
    end

    // Control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= '0;
            r_bits      <= '0;
            for (int i = 0; i < NUM_THR; i++) r_thr[i] <= THR_RESET[i];
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (out_free)   r_out_valid <= r_in_valid;
            if (adv) begin
                r_shift <= n_shift;
                r_bits  <= n_bits;
            end
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_THR))) begin
                r_thr[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_data <= i_in_data;
        if (adv)                      r_out_data <= n_out;
    end

endmodule
`default_nettype wire

// ===== hdl/nec_ir_frame_decoder_checker.sv =====
// Port-level checker for the NEC IR frame decoder, bound to the top level.
`default_nettype none
`include "nec_ir_frame_decoder_defines.svh"
module nec_ir_frame_decoder_checker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  o_out_valid,
    input  wire                                  i_out_ready,
    input  nec_pkg::t_out_word                   o_out_data
);
    import nec_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BITS);

    logic read_done;
    logic not_ready;
    logic nr_fields_ok;
    logic out_stall;

    // Result word classes
    assign read_done    = o_out_valid &&
                          (o_out_data.status == ST_VALID || o_out_data.status == ST_BADCHECK);
    assign not_ready    = o_out_valid && (o_out_data.status == ST_NOTREADY);
    assign nr_fields_ok = (o_out_data.bit_count != FULL_CNT) && (o_out_data.command == '0);
    assign out_stall    = o_out_valid && !i_out_ready;

    // A completed read always leaves the count cleared
    `NEC_ASSERT_NOW(a_read_clears, read_done, o_out_data.bit_count == '0, "read left bits held")
    // Not ready means the frame was short of a full word
    `NEC_ASSERT_NOW(a_notready_cnt, not_ready, nr_fields_ok, "bad not-ready word")
    // Count never runs past a frame
    `NEC_ASSERT_NOW(a_cnt_range, o_out_valid, o_out_data.bit_count <= FULL_CNT, "count overrun")
    // Stalled result holds
    `NEC_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data), "stall broken")

endmodule

bind nec_ir_frame_decoder nec_ir_frame_decoder_checker u_nec_chk (.*);
`default_nettype wire

// ===== tb/nec_ir_frame_decoder_test.sv =====
// Self-checking testbench of the NEC IR frame decoder: random frames, noise and config phases.
module nec_ir_frame_decoder_test;
    import nec_pkg::*;

    localparam logic OP_READ = ~OP_CAPTURE;

    // Threshold register indexes, plus the two unused slots of the index field
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BELOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_BELOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BELOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_BELOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BELOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_BELOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI     = 3'd7;

    localparam int unsigned PIPE_DELAY  = 2;
    localparam int unsigned SETTLE      = PIPE_DELAY + 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT    = 18;

    // Tracks thresholds, frame bits and bit count; queues the decoded words due
    class ir_frame_tracker;
        logic [PERIOD_W-1:0]   thr [NUM_THR];
        logic [FRAME_BITS-1:0] frame;
        logic [CNT_W-1:0]      held;
        t_out_word             decoded_due [$];
        int unsigned           faults;

        function new();
            foreach (thr[r]) thr[r] = THR_RESET[r];
            frame  = '0;
            held   = '0;
            faults = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
            if (idx < NUM_THR) thr[idx] = val;
        endfunction

        // first threshold that the period falls below decides the band
        function logic [2:0] band_of(logic [PERIOD_W-1:0] p);
            if (p < thr[CFG_ERROR_BELOW])  return BAND_ERROR;
            if (p < thr[CFG_SHORT_BELOW])  return BAND_SHORT;
            if (p < thr[CFG_LONG_BELOW])   return BAND_LONG;
            if (p < thr[CFG_REPEAT_BELOW]) return BAND_REPEAT;
            if (p < thr[CFG_HEADER_BELOW]) return BAND_HEADER;
            if (p < thr[CFG_LEAD_BELOW])   return BAND_LEAD;
            return BAND_ERROR;
        endfunction

        function void take_word(t_in_word w);
            t_out_word e;
            e.status  = ST_TAKEN;
            e.command = '0;
            if (w.opcode == OP_CAPTURE) begin
                // captures are dropped once the frame is full
                if (held < FRAME_BITS) begin
                    case (band_of(w.period))
                        BAND_SHORT: begin
                            frame = frame >> 1;
                            held  = held + 1'b1;
                        end
                        BAND_LONG: begin
                            frame = {1'b1, frame[FRAME_BITS-1:1]};
                            held  = held + 1'b1;
                        end
                        BAND_HEADER: begin
                            frame = '0;
                            held  = '0;
                        end
                        BAND_REPEAT: begin
                            if (held == 0) held = CNT_W'(FRAME_BITS);
                        end
                        default: ;
                    endcase
                end
            end else if (held != FRAME_BITS) begin
                e.status = ST_NOTREADY;
            end else begin
                held = '0;
                if ((frame[7:0] ^ frame[15:8]) == BYTE_ONES &&
                    (frame[23:16] ^ frame[31:24]) == BYTE_ONES) begin
                    e.status  = ST_VALID;
                    e.command = frame[23:16];
                end else begin
                    e.status = ST_BADCHECK;
                end
            end
            e.bit_count = held;
            decoded_due.push_back(e);
        endfunction

        function void match_result(t_out_word got);
            t_out_word want;
            if (decoded_due.size() == 0) begin
                $display("%0t: unexpected word: status %0d command %02h count %0d",
                         $time, got.status, got.command, got.bit_count);
                faults++;
                return;
            end
            want = decoded_due.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                faults++;
            end
            if (got.command !== want.command) begin
                $display("%0t: command expected %02h actual %02h",
                         $time, want.command, got.command);
                faults++;
            end
            if (got.bit_count !== want.bit_count) begin
                $display("%0t: bit_count expected %0d actual %0d",
                         $time, want.bit_count, got.bit_count);
                faults++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_data   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_data;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [PERIOD_W-1:0]   cfg_data  = '0;
    logic                  cfg_ready;

    logic                  quiet     = 1'b0;
    int unsigned           cycles    = 0;
    int unsigned           sent      = 0;
    logic [PERIOD_W-1:0]   cur_thr [NUM_THR];
    ir_frame_tracker       tracker   = new();

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    nec_ir_frame_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Receiver stalls, and the monitor of all three channels
    always @(posedge clk) begin
        cycles    <= cycles + 1;
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n) begin
            if (cfg_valid && cfg_ready) tracker.set_threshold(cfg_index, cfg_data);
            if (out_valid && out_ready) tracker.match_result(out_data);
            if (in_valid && in_ready) tracker.take_word(in_data);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("nec_ir_frame_decoder_test: FAIL");
        $finish;
    end

    // One input word, with random idle cycles ahead of it unless quiet
    task automatic send(input logic op, input logic [PERIOD_W-1:0] p);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, period: p};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // Hold off the sender until every due word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.decoded_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write cur_thr to the block, plus junk to the unused indexes
    task automatic load_thresholds();
        for (int r = CFG_ERROR_BELOW; r <= CFG_SPARE_HI; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= (r < CFG_SPARE_LO) ? cur_thr[r] : PERIOD_W'($urandom);
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic pick_ascending();
        int unsigned acc = 0;
        foreach (cur_thr[r]) begin
            acc += $urandom_range(6000);
            if (acc > 16'hFFFF) acc = 16'hFFFF;
            cur_thr[r] = PERIOD_W'(acc);
        end
    endtask

    // Random period inside a band under the current thresholds; any value if empty
    function automatic logic [PERIOD_W-1:0] pick_period(logic [2:0] band);
        int unsigned lo = 0;
        int unsigned hi;
        for (int r = 0; r < band; r++) if (cur_thr[r] > lo) lo = cur_thr[r];
        hi = cur_thr[band];
        if (lo < hi) return PERIOD_W'($urandom_range(hi - 1, lo));
        return PERIOD_W'($urandom);
    endfunction

    // Header, 32 bits LSB first, read; sometimes corrupt, cut short or repeated
    task automatic send_frame();
        logic [7:0]            addr;
        logic [7:0]            cmd;
        logic [FRAME_BITS-1:0] bits;
        int unsigned           n;
        addr = 8'($urandom);
        cmd  = 8'($urandom);
        bits = {~cmd, cmd, ~addr, addr};
        if ($urandom_range(99) < 20) bits[$urandom_range(FRAME_BITS - 1)] ^= 1'b1;
        n = ($urandom_range(99) < 10) ? $urandom_range(FRAME_BITS - 1) : FRAME_BITS;
        send(OP_CAPTURE, pick_period(BAND_HEADER));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 2) send(OP_CAPTURE, PERIOD_W'($urandom));
            if ($urandom_range(99) < 1) send(OP_CAPTURE, pick_period(BAND_LEAD));
            send(OP_CAPTURE, pick_period(bits[i] ? BAND_LONG : BAND_SHORT));
        end
        if ($urandom_range(99) < 10) send(OP_CAPTURE, pick_period(BAND_LONG));
        send(OP_READ, PERIOD_W'($urandom));
        if ($urandom_range(99) < 30) begin
            send(OP_CAPTURE, pick_period(BAND_REPEAT));
            send(OP_READ, PERIOD_W'($urandom));
        end
    endtask

    task automatic run_traffic(input int unsigned count);
        int unsigned goal = sent + count;
        while (sent < goal) begin
            if ($urandom_range(99) < 75) send_frame();
            else send(($urandom_range(99) < 70) ? OP_CAPTURE : OP_READ, PERIOD_W'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned count);
        drain();
        load_thresholds();
        run_traffic(count);
    endtask

    initial begin
        foreach (cur_thr[r]) cur_thr[r] = THR_RESET[r];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset thresholds: band edges, full frame, repeat, reads
        send(OP_READ, '1);
        send(OP_CAPTURE, THR_RESET[CFG_ERROR_BELOW]);
        send(OP_CAPTURE, THR_RESET[CFG_ERROR_BELOW] - 1'b1);
        send(OP_CAPTURE, THR_RESET[CFG_SHORT_BELOW]);
        send(OP_CAPTURE, THR_RESET[CFG_SHORT_BELOW] - 1'b1);
        send(OP_CAPTURE, '0);
        send(OP_CAPTURE, '1);
        send(OP_CAPTURE, THR_RESET[CFG_LEAD_BELOW] - 1'b1);
        send(OP_CAPTURE, THR_RESET[CFG_LEAD_BELOW]);
        send(OP_CAPTURE, THR_RESET[CFG_REPEAT_BELOW] - 1'b1);
        send(OP_READ, '0);
        send(OP_CAPTURE, THR_RESET[CFG_HEADER_BELOW] - 1'b1);
        send(OP_CAPTURE, THR_RESET[CFG_LONG_BELOW]);
        send(OP_CAPTURE, THR_RESET[CFG_LONG_BELOW] - 1'b1);
        send(OP_CAPTURE, THR_RESET[CFG_HEADER_BELOW]);
        send(OP_READ, '0);
        send(OP_READ, '1);
        send(OP_CAPTURE, THR_RESET[CFG_REPEAT_BELOW]);
        send(OP_CAPTURE, THR_RESET[CFG_LONG_BELOW]);
        send(OP_READ, '0);

        // Reset values written back explicitly
        run_phase(300);

        pick_ascending();
        run_phase(300);

        // Narrowest bands, zero and full-scale edges
        cur_thr = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF};
        run_phase(250);

        // Thresholds out of order
        foreach (cur_thr[r]) cur_thr[r] = PERIOD_W'($urandom);
        run_phase(250);

        // Everything short but the top value
        cur_thr = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        run_phase(100);

        // Back-to-back stretch with no idling on either side, then random traffic again
        pick_ascending();
        quiet = 1'b1;
        run_phase(150);
        quiet = 1'b0;
        run_traffic(150);

        drain();
        if (tracker.faults == 0) begin
            $display("nec_ir_frame_decoder_test: PASS");
        end else begin
            $display("nec_ir_frame_decoder_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nec_pkg.sv
hdl/nec_ir_frame_decoder.sv
hdl/nec_ir_frame_decoder_checker.sv
tb/nec_ir_frame_decoder_test.sv
